>>> rtl/cavl_pkg.sv
// ============================================================================
// cavl_pkg
// Shared widths, register indexes, reset values, product term codes and the
// channel payload, configuration and command types of the angle/velocity loop.
// ============================================================================
`default_nettype none

package cavl_pkg;

    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int DATA_WIDTH_DEFAULT    = 32;

    localparam int IN_W        = 32;
    localparam int GAIN_W      = 32;
    localparam int CHUNK_W     = 32;
    localparam int INTEGRAL_W  = 32;
    localparam int ILIM_W      = 31;
    localparam int OLIM_W      = 15;
    localparam int DRIVE_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int TERM_W      = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_KP         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_KD         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_KP      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_KI      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDFORWARD_GAIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT     = 3'd6;

    localparam logic [GAIN_W-1:0] ANGLE_KP_RESET         = 32'd1507328;
    localparam logic [GAIN_W-1:0] ANGLE_KD_RESET         = 32'd13107200;
    localparam logic [GAIN_W-1:0] VELOCITY_KP_RESET      = 32'd393216000;
    localparam logic [GAIN_W-1:0] VELOCITY_KI_RESET      = 32'd32768000;
    localparam logic [GAIN_W-1:0] FEEDFORWARD_GAIN_RESET = 32'd91750400;
    localparam logic [ILIM_W-1:0] INTEGRAL_LIMIT_RESET   = 31'd229376;
    localparam logic [OLIM_W-1:0] OUTPUT_LIMIT_RESET     = 15'd25000;

    localparam logic [TERM_W-1:0] TERM_E_KP   = 3'd0;
    localparam logic [TERM_W-1:0] TERM_SUM_KD = 3'd1;
    localparam logic [TERM_W-1:0] TERM_VT_FF  = 3'd2;
    localparam logic [TERM_W-1:0] TERM_VE_VKP = 3'd3;
    localparam logic [TERM_W-1:0] TERM_INT_KI = 3'd4;

    typedef struct packed {
        logic signed [IN_W-1:0] target_angle;
        logic signed [IN_W-1:0] measured_angle;
        logic signed [IN_W-1:0] measured_velocity;
    } cavl_in_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_voltage;
    } cavl_out_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cavl_cfg_wr_t;

    typedef struct packed {
        logic [GAIN_W-1:0] angle_kp;
        logic [GAIN_W-1:0] angle_kd;
        logic [GAIN_W-1:0] velocity_kp;
        logic [GAIN_W-1:0] velocity_ki;
        logic [GAIN_W-1:0] feedforward_gain;
        logic [ILIM_W-1:0] integral_limit;
        logic [OLIM_W-1:0] output_limit;
    } cavl_cfg_t;

    typedef struct packed {
        logic              load;
        logic              diff;
        logic              sum;
        logic              acc_clr;
        logic              mac_en;
        logic [TERM_W-1:0] term;
        logic              shift_outer;
        logic              sat_outer;
        logic              vel_err;
        logic              integ;
        logic              shift_inner;
        logic              drive;
    } cavl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/cavl_stream_if.sv
// ============================================================================
// cavl_stream_if
// Valid/ready channel with a typed payload, one per transaction stream.
// ============================================================================
`default_nettype none

interface cavl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/cascaded_angle_velocity_loop_core.sv
// ============================================================================
// cascaded_angle_velocity_loop_core
// Cascaded PD angle loop feeding a feedforward PI velocity loop; one drive
// command per control tick.
// ============================================================================
//  channel   | dir | payload                                          | handshake
//  ----------+-----+--------------------------------------------------+----------
//  in_item   | in  | target_angle, measured_angle, measured_velocity  | valid/ready
//  out_item  | out | drive_voltage                                    | valid/ready
//  cfg       | in  | index, data (register write)                     | valid/ready
//
//  The shared 33x33 multiplier walks five products per tick in NCH chunks of
//  32 operand bits each. A new tick is taken once the previous one has
//  reached the output register; a stalled output holds the following tick in
//  its final state.
//  Reset restores register defaults and clears the loop history at once.
//  cfg is always ready.
// ============================================================================
`default_nettype none

module cascaded_angle_velocity_loop_core #(
    parameter int FRACTION_BITS = cavl_pkg::FRACTION_BITS_DEFAULT,
    parameter int DATA_WIDTH    = cavl_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cavl_stream_if.sink   in_item,
    cavl_stream_if.source out_item,
    cavl_stream_if.sink   cfg
);
    import cavl_pkg::*;

    cavl_cfg_t gains;
    cavl_cmd_t cmd;
    logic      chunk_last;
    logic      in_ready;
    logic      out_valid;
    logic signed [DRIVE_W-1:0] drive_voltage;

    assign in_item.ready                  = in_ready;
    assign out_item.valid                 = out_valid;
    assign out_item.payload.drive_voltage = drive_voltage;

    cavl_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.payload.index),
        .wr_data  (cfg.payload.data),
        .gains    (gains)
    );

    cavl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_item.valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_item.ready),
        .chunk_last (chunk_last),
        .cmd        (cmd)
    );

    cavl_dp #(
        .FRACTION_BITS (FRACTION_BITS),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .gains             (gains),
        .target_angle      (in_item.payload.target_angle),
        .measured_angle    (in_item.payload.measured_angle),
        .measured_velocity (in_item.payload.measured_velocity),
        .chunk_last        (chunk_last),
        .drive_voltage     (drive_voltage)
    );

endmodule

`default_nettype wire

>>> rtl/cavl_regs.sv
// ============================================================================
// cavl_regs
// Configuration register file: gains and limits, written one register per
// transaction; writes to unknown indexes are dropped.
// ============================================================================
`default_nettype none

module cavl_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_valid,
    output logic                                 wr_ready,
    input  wire logic [cavl_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [cavl_pkg::CFG_DATA_W-1:0]  wr_data,
    output cavl_pkg::cavl_cfg_t                  gains
);
    import cavl_pkg::*;

    cavl_cfg_t cfg_reg;
    cavl_cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign gains    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                REG_ANGLE_KP:         cfg_next.angle_kp         = wr_data;
                REG_ANGLE_KD:         cfg_next.angle_kd         = wr_data;
                REG_VELOCITY_KP:      cfg_next.velocity_kp      = wr_data;
                REG_VELOCITY_KI:      cfg_next.velocity_ki      = wr_data;
                REG_FEEDFORWARD_GAIN: cfg_next.feedforward_gain = wr_data;
                REG_INTEGRAL_LIMIT:   cfg_next.integral_limit   = wr_data[ILIM_W-1:0];
                REG_OUTPUT_LIMIT:     cfg_next.output_limit     = wr_data[OLIM_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_kp         <= ANGLE_KP_RESET;
            cfg_reg.angle_kd         <= ANGLE_KD_RESET;
            cfg_reg.velocity_kp      <= VELOCITY_KP_RESET;
            cfg_reg.velocity_ki      <= VELOCITY_KI_RESET;
            cfg_reg.feedforward_gain <= FEEDFORWARD_GAIN_RESET;
            cfg_reg.integral_limit   <= INTEGRAL_LIMIT_RESET;
            cfg_reg.output_limit     <= OUTPUT_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cavl_ctrl.sv
// ============================================================================
// cavl_ctrl
// Sequencer for one control tick: error setup, outer multiply-accumulate,
// velocity target and error, integral update, inner multiply-accumulate, drive output.
// ============================================================================
`default_nettype none

module cavl_ctrl (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire logic       chunk_last,
    output cavl_pkg::cavl_cmd_t cmd
);
    import cavl_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIFF   = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_MAC    = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_SH_OUT = 4'd5;
    localparam logic [3:0] S_SAT    = 4'd6;
    localparam logic [3:0] S_VE     = 4'd7;
    localparam logic [3:0] S_INT    = 4'd8;
    localparam logic [3:0] S_SH_IN  = 4'd9;
    localparam logic [3:0] S_DRIVE  = 4'd10;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [TERM_W-1:0] term_reg;
    logic [TERM_W-1:0] term_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.term       = term_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum     = 1'b1;
                cmd.acc_clr = 1'b1;
                term_next   = TERM_E_KP;
                state_next  = S_MAC;
            end
            S_MAC:
            begin
                cmd.mac_en = 1'b1;
                if (chunk_last)
                begin
                    unique case (term_reg)
                        TERM_E_KP:   term_next  = TERM_SUM_KD;
                        TERM_VT_FF:  term_next  = TERM_VE_VKP;
                        TERM_VE_VKP: term_next  = TERM_INT_KI;
                        default:     state_next = S_DRAIN;
                    endcase
                end
            end
            S_DRAIN:
            begin
                state_next = (term_reg == TERM_SUM_KD) ? S_SH_OUT : S_SH_IN;
            end
            S_SH_OUT:
            begin
                cmd.shift_outer = 1'b1;
                state_next      = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat_outer = 1'b1;
                state_next    = S_VE;
            end
            S_VE:
            begin
                cmd.vel_err = 1'b1;
                state_next  = S_INT;
            end
            S_INT:
            begin
                cmd.integ   = 1'b1;
                cmd.acc_clr = 1'b1;
                term_next   = TERM_VT_FF;
                state_next  = S_MAC;
            end
            S_SH_IN:
            begin
                cmd.shift_inner = 1'b1;
                state_next      = S_DRIVE;
            end
            S_DRIVE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.drive      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            term_reg      <= TERM_E_KP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cavl_dp.sv
// ============================================================================
// cavl_dp
// Datapath: error registers, chunked signed-by-unsigned multiply-accumulate,
// truncating shifts, saturation, integral clamp and drive clamp.
// ============================================================================
`default_nettype none

module cavl_dp #(
    parameter int FRACTION_BITS = cavl_pkg::FRACTION_BITS_DEFAULT,
    parameter int DATA_WIDTH    = cavl_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire cavl_pkg::cavl_cmd_t                cmd,
    input  wire cavl_pkg::cavl_cfg_t                gains,
    input  wire logic signed [cavl_pkg::IN_W-1:0]   target_angle,
    input  wire logic signed [cavl_pkg::IN_W-1:0]   measured_angle,
    input  wire logic signed [cavl_pkg::IN_W-1:0]   measured_velocity,
    output logic                                    chunk_last,
    output logic signed [cavl_pkg::DRIVE_W-1:0]     drive_voltage
);
    import cavl_pkg::*;

    localparam int FB     = FRACTION_BITS;
    localparam int DW     = DATA_WIDTH;
    localparam int CH     = CHUNK_W;
    localparam int DIF_W  = ((DW > IN_W + 1) ? DW : IN_W + 1) + 1;
    localparam int D_W    = DW + 1;
    localparam int SUM_W  = DW + 2;
    localparam int VX_W   = (DW > IN_W) ? DW : IN_W;
    localparam int VE_W   = VX_W + 1;
    localparam int IS_W   = VE_W + 1;
    localparam int OP_W   = (SUM_W > VE_W) ? SUM_W : VE_W;
    localparam int NCH    = (OP_W + CH - 1) / CH;
    localparam int PAD_W  = NCH * CH;
    localparam int K_W    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PROD_W = CH + GAIN_W + 2;
    localparam int ACC_W  = OP_W + GAIN_W + 2;
    localparam int T1_W   = ACC_W - FB;

    localparam logic signed [DIF_W-1:0] E_MAX =
        {{(DIF_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [DIF_W-1:0] E_MIN = ~E_MAX;
    localparam logic signed [T1_W-1:0] VT_MAX =
        {{(T1_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [T1_W-1:0] VT_MIN = ~VT_MAX;
    localparam logic [ACC_W-1:0] MASK_OUTER = {{(ACC_W - FB){1'b0}}, {FB{1'b1}}};
    localparam logic [ACC_W-1:0] MASK_INNER =
        {{(ACC_W - 2 * FB){1'b0}}, {(2 * FB){1'b1}}};

    logic signed [DW-1:0]         e_reg;
    logic signed [DW-1:0]         prev_e_reg;
    logic signed [D_W-1:0]        d_reg;
    logic signed [D_W-1:0]        prev_d_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [IN_W-1:0]       mv_reg;
    logic signed [DW-1:0]         vt_reg;
    logic signed [VE_W-1:0]       ve_reg;
    logic signed [INTEGRAL_W-1:0] integ_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic [K_W-1:0]               pk_reg;
    logic                         pvalid_reg;
    logic [K_W-1:0]               k_reg;
    logic signed [T1_W-1:0]       tz_reg;
    logic signed [DRIVE_W-1:0]    drive_reg;

    logic signed [DIF_W-1:0]      dif;
    logic signed [DW-1:0]         e_next;
    logic signed [PAD_W-1:0]      op;
    logic [GAIN_W-1:0]            gain;
    logic [CH-1:0]                chunk_bits;
    logic signed [CH:0]           chunk_s;
    logic signed [GAIN_W:0]       gain_s;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [ACC_W-1:0]      prod_ext;
    logic signed [ACC_W-1:0]      part_shift;
    logic [ACC_W-1:0]             bias;
    logic signed [ACC_W-1:0]      biased;
    logic signed [T1_W-1:0]       tz_next;
    logic signed [DW-1:0]         vt_next;
    logic signed [IS_W-1:0]       isum;
    logic signed [IS_W-1:0]       ilim;
    logic signed [IS_W-1:0]       nlim;
    logic signed [INTEGRAL_W-1:0] integ_next;
    logic signed [T1_W-1:0]       olim;
    logic signed [T1_W-1:0]       nolim;
    logic signed [DRIVE_W-1:0]    drive_next;

    assign chunk_last    = (k_reg == K_W'(NCH - 1));
    assign drive_voltage = drive_reg;

    always_comb
    begin
        dif = DIF_W'(target_angle) - DIF_W'(measured_angle);
        if (dif > E_MAX)
            e_next = E_MAX[DW-1:0];
        else if (dif < E_MIN)
            e_next = E_MIN[DW-1:0];
        else
            e_next = dif[DW-1:0];
    end

    always_comb
    begin
        case (cmd.term)
            TERM_E_KP:
            begin
                op   = PAD_W'(e_reg);
                gain = gains.angle_kp;
            end
            TERM_SUM_KD:
            begin
                op   = PAD_W'(sum_reg);
                gain = gains.angle_kd;
            end
            TERM_VT_FF:
            begin
                op   = PAD_W'(vt_reg);
                gain = gains.feedforward_gain;
            end
            TERM_VE_VKP:
            begin
                op   = PAD_W'(ve_reg);
                gain = gains.velocity_kp;
            end
            TERM_INT_KI:
            begin
                op   = PAD_W'(integ_reg);
                gain = gains.velocity_ki;
            end
            default:
            begin
                op   = '0;
                gain = '0;
            end
        endcase
        chunk_bits = op[k_reg * CH +: CH];
        chunk_s    = chunk_last ? {chunk_bits[CH-1], chunk_bits} : {1'b0, chunk_bits};
        gain_s     = {1'b0, gain};
        prod_next  = chunk_s * gain_s;
    end

    assign prod_ext   = ACC_W'(prod_reg);
    assign part_shift = prod_ext << (CH * pk_reg);

    always_comb
    begin
        bias    = acc_reg[ACC_W-1] ? (cmd.shift_inner ? MASK_INNER : MASK_OUTER) : '0;
        biased  = acc_reg + signed'(bias);
        if (cmd.shift_inner)
            tz_next = T1_W'(signed'(biased[ACC_W-1:2*FB]));
        else
            tz_next = biased[ACC_W-1:FB];
    end

    always_comb
    begin
        if (tz_reg > VT_MAX)
            vt_next = VT_MAX[DW-1:0];
        else if (tz_reg < VT_MIN)
            vt_next = VT_MIN[DW-1:0];
        else
            vt_next = tz_reg[DW-1:0];
    end

    always_comb
    begin
        isum = IS_W'(integ_reg) + IS_W'(ve_reg);
        ilim = signed'(IS_W'(gains.integral_limit));
        nlim = -ilim;
        if (isum > ilim)
            integ_next = ilim[INTEGRAL_W-1:0];
        else if (isum < nlim)
            integ_next = nlim[INTEGRAL_W-1:0];
        else
            integ_next = isum[INTEGRAL_W-1:0];
    end

    always_comb
    begin
        olim  = signed'(T1_W'(gains.output_limit));
        nolim = -olim;
        if (tz_reg > olim)
            drive_next = olim[DRIVE_W-1:0];
        else if (tz_reg < nolim)
            drive_next = nolim[DRIVE_W-1:0];
        else
            drive_next = tz_reg[DRIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_e_reg <= '0;
            prev_d_reg <= '0;
            integ_reg  <= '0;
            pvalid_reg <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            pvalid_reg <= cmd.mac_en;
            if (cmd.mac_en)
                k_reg <= chunk_last ? '0 : k_reg + 1'b1;
            if (cmd.sat_outer)
            begin
                prev_e_reg <= e_reg;
                prev_d_reg <= d_reg;
            end
            if (cmd.integ)
                integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg  <= e_next;
            mv_reg <= measured_velocity;
        end
        if (cmd.diff)
            d_reg <= D_W'(e_reg) - D_W'(prev_e_reg);
        if (cmd.sum)
            sum_reg <= SUM_W'(d_reg) + SUM_W'(prev_d_reg);
        if (cmd.mac_en)
        begin
            prod_reg <= prod_next;
            pk_reg   <= k_reg;
        end
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (pvalid_reg)
            acc_reg <= acc_reg + part_shift;
        if (cmd.shift_outer || cmd.shift_inner)
            tz_reg <= tz_next;
        if (cmd.sat_outer)
            vt_reg <= vt_next;
        if (cmd.vel_err)
            ve_reg <= VE_W'(vt_reg) - VE_W'(mv_reg);
        if (cmd.drive)
            drive_reg <= drive_next;
    end

endmodule

`default_nettype wire
